// ----- rtl/bfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsc_pkg
// Shared types and constants of the backlight fade/sleep controller.
// ----------------------------------------------------------------------------
package bfsc_pkg;

  localparam int LEVEL_W   = 8;
  localparam int IDLE_W    = 26;
  localparam int FADE_W    = 4;
  localparam int TMO_W     = 16;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL  = 8'd220;
  localparam logic [FADE_W-1:0]  FADE_PERIOD_MS = 4'd10;
  localparam logic [LEVEL_W-1:0] FAR_DIST       = 8'd20;
  localparam logic [LEVEL_W-1:0] NEAR_DIST      = 8'd5;
  localparam logic [LEVEL_W-1:0] STEP_FAR       = 8'd8;
  localparam logic [LEVEL_W-1:0] STEP_MID       = 8'd4;
  localparam logic [LEVEL_W-1:0] STEP_NEAR      = 8'd1;
  localparam logic [IDLE_W-1:0]  IDLE_MAX       = {IDLE_W{1'b1}};
  localparam logic [IDLE_W-1:0]  MS_PER_SEC     = 26'd1000;

  // Register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_INIT    = 1'b1;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_SET     = 3'd1,
    MODE_WAKE    = 3'd2,
    MODE_SLEEP   = 3'd3,
    MODE_TOGGLE  = 3'd4,
    MODE_RESTART = 3'd5
  } mode_t;

  typedef struct packed {
    logic [IDLE_W-1:0]  sleep_thr;   // timeout_sec * 1000, 0 = off
    logic [LEVEL_W-1:0] init_level;  // raw initial_brightness
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic               awake;
    logic [LEVEL_W-1:0] user_level;
  } res_t;

endpackage

// ----- rtl/bfsc_if.sv -----
// ----------------------------------------------------------------------------
// bfsc_if
// Valid/ready channels of the controller: event input and result output.
// ----------------------------------------------------------------------------
interface bfsc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] level;
  logic       fade;

  modport source (output valid, output mode, output level, output fade, input ready);
  modport sink   (input valid, input mode, input level, input fade, output ready);
endinterface

interface bfsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       awake;
  logic [7:0] user_level;

  modport source (output valid, output duty, output awake, output user_level, input ready);
  modport sink   (input valid, input duty, input awake, input user_level, output ready);
endinterface

// ----- rtl/bfsc_cfg.sv -----
// ----------------------------------------------------------------------------
// bfsc_cfg
// APB register file: timeout and restart brightness.
// ----------------------------------------------------------------------------
module bfsc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfsc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfsc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfsc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output bfsc_pkg::cfg_t                 cfg
);

  logic [bfsc_pkg::TMO_W-1:0]   timeout_r;
  logic [bfsc_pkg::IDLE_W-1:0]  thr_r;
  logic [bfsc_pkg::LEVEL_W-1:0] init_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
      thr_r     <= '0;
      init_r    <= bfsc_pkg::DEFAULT_LEVEL;
    end else if (wr_en) begin
      if (paddr[2] == bfsc_pkg::REG_TIMEOUT) begin
        timeout_r <= pwdata[bfsc_pkg::TMO_W-1:0];
        // 16 x 10 bit constant product, fits in the idle counter width
        thr_r     <= bfsc_pkg::IDLE_W'(pwdata[bfsc_pkg::TMO_W-1:0]) * bfsc_pkg::MS_PER_SEC;
      end else begin
        init_r    <= pwdata[bfsc_pkg::LEVEL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bfsc_pkg::REG_TIMEOUT) begin
      prdata = bfsc_pkg::PDATA_W'(timeout_r);
    end else begin
      prdata = bfsc_pkg::PDATA_W'(init_r);
    end
  end

  assign cfg.sleep_thr  = thr_r;
  assign cfg.init_level = init_r;

endmodule

// ----- rtl/bfsc_core.sv -----
// ----------------------------------------------------------------------------
// bfsc_core
// Fade/sleep state and its registered update per accepted event.
// ----------------------------------------------------------------------------
module bfsc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [2:0]                    mode,
  input  logic [bfsc_pkg::LEVEL_W-1:0]  level,
  input  logic                          fade,
  input  bfsc_pkg::cfg_t                cfg,
  output bfsc_pkg::res_t                res
);

  logic [bfsc_pkg::LEVEL_W-1:0] cur_r, cur_nxt;
  logic [bfsc_pkg::LEVEL_W-1:0] tgt_r, tgt_nxt;
  logic [bfsc_pkg::LEVEL_W-1:0] chosen_r, chosen_nxt;
  logic                         awake_r, awake_nxt;
  logic [bfsc_pkg::FADE_W-1:0]  fade_ms_r, fade_ms_nxt;
  logic [bfsc_pkg::IDLE_W-1:0]  idle_r, idle_nxt;

  logic [bfsc_pkg::LEVEL_W-1:0] diff, step, stepped, init_eff;
  logic [bfsc_pkg::FADE_W-1:0]  fade_inc;
  logic [bfsc_pkg::IDLE_W-1:0]  idle_inc;
  logic                         going_up;

  // one fade step toward target; step sizes never exceed the distance
  always_comb begin
    going_up = tgt_r > cur_r;
    diff     = going_up ? (tgt_r - cur_r) : (cur_r - tgt_r);
    if (diff > bfsc_pkg::FAR_DIST) begin
      step = bfsc_pkg::STEP_FAR;
    end else if (diff > bfsc_pkg::NEAR_DIST) begin
      step = bfsc_pkg::STEP_MID;
    end else if (diff != '0) begin
      step = bfsc_pkg::STEP_NEAR;
    end else begin
      step = '0;
    end
    stepped  = going_up ? (cur_r + step) : (cur_r - step);
    fade_inc = fade_ms_r + 1'b1;
    idle_inc = (idle_r == bfsc_pkg::IDLE_MAX) ? idle_r : (idle_r + 1'b1);
    init_eff = (cfg.init_level != '0) ? cfg.init_level : bfsc_pkg::DEFAULT_LEVEL;
  end

  always_comb begin
    cur_nxt     = cur_r;
    tgt_nxt     = tgt_r;
    chosen_nxt  = chosen_r;
    awake_nxt   = awake_r;
    fade_ms_nxt = fade_ms_r;
    idle_nxt    = idle_r;
    if (accept) begin
      case (bfsc_pkg::mode_t'(mode))
        bfsc_pkg::MODE_TICK: begin
          if (fade_inc >= bfsc_pkg::FADE_PERIOD_MS) begin
            fade_ms_nxt = '0;
            cur_nxt     = stepped;
          end else begin
            fade_ms_nxt = fade_inc;
          end
          idle_nxt = idle_inc;
          if (awake_r && (cfg.sleep_thr != '0) && (idle_inc >= cfg.sleep_thr)) begin
            awake_nxt = 1'b0;
            tgt_nxt   = '0;
          end
        end
        bfsc_pkg::MODE_SET: begin
          chosen_nxt = level;
          idle_nxt   = '0;
          if (awake_r) begin
            tgt_nxt = level;
            if (!fade) begin
              cur_nxt = level;
            end
          end
        end
        bfsc_pkg::MODE_WAKE: begin
          idle_nxt = '0;
          if (!awake_r) begin
            awake_nxt = 1'b1;
            tgt_nxt   = chosen_r;
          end
        end
        bfsc_pkg::MODE_SLEEP: begin
          if (awake_r) begin
            awake_nxt = 1'b0;
            tgt_nxt   = '0;
          end
        end
        bfsc_pkg::MODE_TOGGLE: begin
          if (awake_r) begin
            awake_nxt = 1'b0;
            tgt_nxt   = '0;
          end else begin
            awake_nxt = 1'b1;
            tgt_nxt   = chosen_r;
            idle_nxt  = '0;
          end
        end
        bfsc_pkg::MODE_RESTART: begin
          chosen_nxt = init_eff;
          tgt_nxt    = init_eff;
          cur_nxt    = '0;
          awake_nxt  = 1'b1;
          idle_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      tgt_r     <= bfsc_pkg::DEFAULT_LEVEL;
      chosen_r  <= bfsc_pkg::DEFAULT_LEVEL;
      awake_r   <= 1'b1;
      fade_ms_r <= '0;
      idle_r    <= '0;
    end else begin
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
      chosen_r  <= chosen_nxt;
      awake_r   <= awake_nxt;
      fade_ms_r <= fade_ms_nxt;
      idle_r    <= idle_nxt;
    end
  end

  assign res.duty       = cur_nxt;
  assign res.awake      = awake_nxt;
  assign res.user_level = chosen_nxt;

  // fade counter wraps before it reaches the period
  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    fade_ms_r < bfsc_pkg::FADE_PERIOD_MS)
    else $error("fade counter out of range");

  // asleep always means fading toward black
  a_sleep_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    !awake_r |-> (tgt_r == '0))
    else $error("asleep with nonzero target");

  // state only moves on an accepted transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cur_r) && $stable(idle_r) && $stable(awake_r))
    else $error("state changed without a transaction");

endmodule

// ----- rtl/bfsc_obuf.sv -----
// ----------------------------------------------------------------------------
// bfsc_obuf
// Result register plus one skid entry, decouples input from output stalls.
// ----------------------------------------------------------------------------
module bfsc_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfsc_pkg::res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bfsc_pkg::res_t out_data
);

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  bfsc_pkg::res_t out_data_r, out_data_nxt;
  bfsc_pkg::res_t skid_data_r, skid_data_nxt;
  logic           pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = push;
        out_data_nxt   = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry is only used behind a held result
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without result");

  // no push lands on a full skid entry
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push into full buffer");

endmodule

// ----- rtl/backlight_fade_sleep_controller_unit.sv -----
// ----------------------------------------------------------------------------
// backlight_fade_sleep_controller_unit
// Backlight PWM duty controller with timed fade and inactivity sleep.
// ----------------------------------------------------------------------------
// One event per transaction (1 ms tick, set brightness, wake, sleep, toggle,
// restart), one result per event carrying duty, awake and the user level.
// Throughput is one event per clock while the skid entry is free: the whole
// state update is a single register-to-register pass, and the result is
// registered at acceptance. A one-entry skid buffer behind the output
// register keeps the input ready for one more event while a result is
// held; in_ch.ready drops only when both are full. Every 10 ticks the duty
// steps 8, 4 or 1 toward the target. Auto-sleep fires when the saturating
// idle count reaches timeout_sec * 1000; the product is formed at register
// write time, so write configuration only while no events are in flight.
// No clearing pass after reset; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module backlight_fade_sleep_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  bfsc_in_if.sink                       in_ch,
  bfsc_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bfsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bfsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  bfsc_pkg::cfg_t cfg;
  bfsc_pkg::res_t res;
  bfsc_pkg::res_t out_data;
  logic           in_ready;
  logic           accept;

  // config registers; threshold precomputed on write
  bfsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // state update happens at the accepting edge; res is the post-event view
  bfsc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .mode   (in_ch.mode),
    .level  (in_ch.level),
    .fade   (in_ch.fade),
    .cfg    (cfg),
    .res    (res)
  );

  // result register + skid
  bfsc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.duty       = out_data.duty;
  assign out_ch.awake      = out_data.awake;
  assign out_ch.user_level = out_data.user_level;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backlight fade/sleep controller.
// Sends events over the valid/ready input channel with random gaps and
// applies random back-pressure on the result channel. A tracker class mirrors
// the duty, target, user level, wake state and the tick counters, and checks
// each result field by field. Several register settings are covered,
// including both extremes of each register.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the block ignores
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Mismatch lines printed before going quiet (all are still counted)
  localparam int PRINT_CAP = 100;

  // --------------------------------------------------------------------------
  // Duty tracker: shadow state of the controller plus the queue of
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class duty_tracker;
    logic [bfsc_pkg::TMO_W-1:0]   timeout_s;
    logic [bfsc_pkg::LEVEL_W-1:0] restart_lvl;
    logic [bfsc_pkg::LEVEL_W-1:0] duty_lvl;
    logic [bfsc_pkg::LEVEL_W-1:0] target_lvl;
    logic [bfsc_pkg::LEVEL_W-1:0] user_lvl;
    logic                         awake_st;
    logic [bfsc_pkg::FADE_W-1:0]  fade_cnt;
    logic [bfsc_pkg::IDLE_W-1:0]  idle_cnt;
    bfsc_pkg::res_t               results_due[$];
    int                           fails;

    function new();
      fails       = 0;
      timeout_s   = '0;
      restart_lvl = bfsc_pkg::DEFAULT_LEVEL;
      duty_lvl    = '0;
      target_lvl  = bfsc_pkg::DEFAULT_LEVEL;
      user_lvl    = bfsc_pkg::DEFAULT_LEVEL;
      awake_st    = 1'b1;
      fade_cnt    = '0;
      idle_cnt    = '0;
    endfunction

    function void set_reg(logic reg_idx, logic [bfsc_pkg::PDATA_W-1:0] val);
      if (reg_idx == bfsc_pkg::REG_TIMEOUT) begin
        timeout_s = val[bfsc_pkg::TMO_W-1:0];
      end else begin
        restart_lvl = val[bfsc_pkg::LEVEL_W-1:0];
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // one fade step toward the target, never past it
    function void fade_toward();
      logic [bfsc_pkg::LEVEL_W-1:0] diff;
      logic [bfsc_pkg::LEVEL_W-1:0] stp;
      if (duty_lvl == target_lvl) return;
      diff = (target_lvl > duty_lvl) ? target_lvl - duty_lvl : duty_lvl - target_lvl;
      stp  = (diff > bfsc_pkg::FAR_DIST) ? bfsc_pkg::STEP_FAR :
             ((diff > bfsc_pkg::NEAR_DIST) ? bfsc_pkg::STEP_MID : bfsc_pkg::STEP_NEAR);
      if (stp > diff) stp = diff;
      if (target_lvl > duty_lvl) duty_lvl = duty_lvl + stp;
      else duty_lvl = duty_lvl - stp;
    endfunction

    function void fall_asleep();
      if (awake_st) begin
        awake_st   = 1'b0;
        target_lvl = '0;
      end
    endfunction

    function void wake_up();
      idle_cnt = '0;
      if (!awake_st) begin
        awake_st   = 1'b1;
        target_lvl = user_lvl;
      end
    endfunction

    function void choose_level(logic [bfsc_pkg::LEVEL_W-1:0] lvl, logic fade_on);
      user_lvl = lvl;
      if (awake_st) begin
        target_lvl = lvl;
        if (!fade_on) duty_lvl = lvl;
      end
      idle_cnt = '0;
    endfunction

    function void tick_ms();
      fade_cnt = fade_cnt + 1'b1;
      if (fade_cnt >= bfsc_pkg::FADE_PERIOD_MS) begin
        fade_cnt = '0;
        fade_toward();
      end
      if (idle_cnt != bfsc_pkg::IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
      if (awake_st && timeout_s != '0 &&
          32'(idle_cnt) >= 32'(timeout_s) * 32'(bfsc_pkg::MS_PER_SEC)) fall_asleep();
    endfunction

    function void restart_fade();
      logic [bfsc_pkg::LEVEL_W-1:0] init_lvl;
      init_lvl   = (restart_lvl != '0) ? restart_lvl : bfsc_pkg::DEFAULT_LEVEL;
      user_lvl   = init_lvl;
      target_lvl = init_lvl;
      duty_lvl   = '0;
      awake_st   = 1'b1;
      idle_cnt   = '0;
    endfunction

    // Accepted event: update the shadow state and queue the result it owes.
    function void apply_event(logic [2:0] m, logic [bfsc_pkg::LEVEL_W-1:0] lvl,
                              logic fade_on);
      bfsc_pkg::res_t r;
      case (m)
        bfsc_pkg::MODE_TICK:    tick_ms();
        bfsc_pkg::MODE_SET:     choose_level(lvl, fade_on);
        bfsc_pkg::MODE_WAKE:    wake_up();
        bfsc_pkg::MODE_SLEEP:   fall_asleep();
        bfsc_pkg::MODE_TOGGLE: begin
          if (awake_st) fall_asleep();
          else wake_up();
        end
        bfsc_pkg::MODE_RESTART: restart_fade();
        default: ;
      endcase
      r.duty       = duty_lvl;
      r.awake      = awake_st;
      r.user_level = user_lvl;
      results_due.push_back(r);
    endfunction

    task flag_mismatch(string what);
      fails++;
      if (fails <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task match_result(bfsc_pkg::res_t got);
      bfsc_pkg::res_t want;
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result duty=%0d awake=%0d user=%0d",
                                got.duty, got.awake, got.user_level));
        return;
      end
      want = results_due.pop_front();
      if (got.duty !== want.duty)
        flag_mismatch($sformatf("duty got %0d want %0d", got.duty, want.duty));
      if (got.awake !== want.awake)
        flag_mismatch($sformatf("awake got %0d want %0d", got.awake, want.awake));
      if (got.user_level !== want.user_level)
        flag_mismatch($sformatf("user_level got %0d want %0d",
                                got.user_level, want.user_level));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bfsc_pkg::PADDR_W-1:0] paddr;
  logic [bfsc_pkg::PDATA_W-1:0] pwdata;
  logic [bfsc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  bfsc_in_if  ev_if ();
  bfsc_out_if res_if ();

  duty_tracker sb;
  int          quiet_cycles;
  bit          steady;      // 1 = no gaps and no stalls for the current stretch

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  backlight_fade_sleep_controller_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (ev_if),
    .out_ch  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then a long one.
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [bfsc_pkg::LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bfsc_pkg::LEVEL_W'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge. The input transaction
  // is noted before the result check; a result never belongs to an event
  // accepted on the same edge anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bfsc_pkg::res_t got;
    if (rst_n) begin
      if (ev_if.valid && ev_if.ready) sb.apply_event(ev_if.mode, ev_if.level, ev_if.fade);
      if (res_if.valid && res_if.ready) begin
        got.duty       = res_if.duty;
        got.awake      = res_if.awake;
        got.user_level = res_if.user_level;
        sb.match_result(got);
      end
      if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: too long without any transaction means the block is stuck.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Result side back-pressure: random stall runs, short ready bursts.
  initial begin
    int hold;
    int n;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!res_if.ready) begin
        res_if.ready = 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        n = draw_gap();
        if (n > 0) begin
          res_if.ready = 1'b0;
          hold = n - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All called and returning at a falling edge.
  // --------------------------------------------------------------------------
  // One event transaction, preceded by an optional gap. valid stays high on
  // return so back-to-back events need no toggle.
  task automatic send_evt(input logic [2:0] m, input logic [bfsc_pkg::LEVEL_W-1:0] lvl,
                          input logic fade_on);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      ev_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev_if.valid = 1'b1;
    ev_if.mode  = m;
    ev_if.level = lvl;
    ev_if.fade  = fade_on;
    do @(posedge clk); while (!(ev_if.valid && ev_if.ready));
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come back, then let the
  // output register and skid buffer settle.
  task automatic drain();
    ev_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Register write (setup + access), then a read back of the same register.
  task automatic cfg_write(input logic reg_idx, input logic [bfsc_pkg::PDATA_W-1:0] val);
    logic [bfsc_pkg::PDATA_W-1:0] rd;
    int                           w;
    w = (reg_idx == bfsc_pkg::REG_TIMEOUT) ? bfsc_pkg::TMO_W : bfsc_pkg::LEVEL_W;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(reg_idx, val);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if ((rd & ((32'd1 << w) - 1)) !== (val & ((32'd1 << w) - 1)))
      sb.flag_mismatch($sformatf("register %0d reads %0h, written %0h", reg_idx, rd, val));
  endtask

  // Random event mix; the steady flag is redrawn every few dozen events.
  task automatic run_mix(input int n);
    int         r;
    logic [2:0] m;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 50)      m = bfsc_pkg::MODE_TICK;
      else if (r < 70) m = bfsc_pkg::MODE_SET;
      else if (r < 78) m = bfsc_pkg::MODE_WAKE;
      else if (r < 85) m = bfsc_pkg::MODE_SLEEP;
      else if (r < 92) m = bfsc_pkg::MODE_TOGGLE;
      else if (r < 96) m = bfsc_pkg::MODE_RESTART;
      else if (r < 98) m = MODE_SPARE_A;
      else             m = MODE_SPARE_B;
      send_evt(m, pick_level(), 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
  endtask

  // Restart, then an unbroken tick stream: the fade climbs through all three
  // step sizes, settles, auto-sleep fires at the threshold and the duty
  // starts to fade back down. Only ignored modes are sprinkled in, so idle
  // time keeps counting.
  task automatic quiet_stretch(input int n);
    send_evt(bfsc_pkg::MODE_RESTART, pick_level(), 1'b0);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0)
        send_evt(($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B,
                 pick_level(), 1'($urandom_range(0, 1)));
      else
        send_evt(bfsc_pkg::MODE_TICK, pick_level(), 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb           = new();
    quiet_cycles = 0;
    steady       = 1'b0;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    ev_if.valid  = 1'b0;
    ev_if.mode   = bfsc_pkg::MODE_TICK;
    ev_if.level  = '0;
    ev_if.fade   = 1'b0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, registers at their reset values.
    send_evt(MODE_SPARE_A, 8'd255, 1'b1);   // ignored modes echo state
    send_evt(MODE_SPARE_B, 8'd0, 1'b0);
    send_evt(bfsc_pkg::MODE_SET, 8'd255, 1'b0);       // immediate jump to full
    send_evt(bfsc_pkg::MODE_SET, 8'd0, 1'b1);         // fade toward zero
    repeat (10) send_evt(bfsc_pkg::MODE_TICK, 8'd0, 1'b0);  // tenth tick takes a step
    send_evt(bfsc_pkg::MODE_SLEEP, 8'd0, 1'b0);
    send_evt(bfsc_pkg::MODE_SLEEP, 8'd0, 1'b0);       // sleep while asleep: no change
    send_evt(bfsc_pkg::MODE_SET, 8'd0, 1'b0);         // asleep: only user level moves
    send_evt(bfsc_pkg::MODE_SET, 8'd255, 1'b1);
    send_evt(bfsc_pkg::MODE_WAKE, 8'd0, 1'b0);        // target back to user level
    send_evt(bfsc_pkg::MODE_TOGGLE, 8'd0, 1'b0);      // awake -> asleep
    send_evt(bfsc_pkg::MODE_TOGGLE, 8'd0, 1'b0);      // asleep -> awake
    send_evt(bfsc_pkg::MODE_RESTART, 8'd0, 1'b0);     // duty back to 0, fade up
    send_evt(bfsc_pkg::MODE_WAKE, 8'd0, 1'b0);        // awake: only clears idle time
    drain();

    // Auto-sleep off, restart level 0 (falls back to the default).
    cfg_write(bfsc_pkg::REG_TIMEOUT, 32'd0);
    cfg_write(bfsc_pkg::REG_INIT, 32'd0);
    run_mix(50);
    drain();

    // Shortest timeout, brightest restart level.
    cfg_write(bfsc_pkg::REG_TIMEOUT, 32'd1);
    cfg_write(bfsc_pkg::REG_INIT, 32'd255);
    quiet_stretch(1030);
    run_mix(15);
    drain();

    // Longest timeout, dimmest nonzero restart level.
    cfg_write(bfsc_pkg::REG_TIMEOUT, 32'd65535);
    cfg_write(bfsc_pkg::REG_INIT, 32'd1);
    run_mix(20);
    drain();

    // Random setting.
    cfg_write(bfsc_pkg::REG_TIMEOUT, 32'($urandom_range(1, 65534)));
    cfg_write(bfsc_pkg::REG_INIT, 32'($urandom_range(2, 254)));
    run_mix(20);
    drain();

    repeat (8) @(negedge clk);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
